@@ rtl/rrdp_pkg.sv @@
// Shared types and constants of the round-robin device picker.
`timescale 1ns / 1ps
`default_nettype none

package rrdp_pkg;

  // Width of the memory size fields and of the resident byte accumulators.
  localparam int unsigned MEM_BITS = 48;

  // Widths of the request fields.
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned TYPE_W   = 16;
  localparam int unsigned PES_W    = 16;
  localparam int unsigned NUM_W    = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Request kinds carried in the input tuser.
  localparam logic [MODE_W-1:0] MODE_WRITE_DEV = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RESIDENT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PICK      = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DEVICES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS      = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FINISH
  } state_e;

  // One device record as held in the device table memory.
  typedef struct packed {
    logic [PES_W-1:0]    pes_total;
    logic [PES_W-1:0]    busy_pes;
    logic [MEM_BITS-1:0] free_mem;
    logic [TYPE_W-1:0]   dev_type;
  } dev_rec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // a request is taken this cycle
    logic start;    // a pick request is taken: load the scan
    logic rd_en;    // read the device record at the scan index
    logic eval;     // judge the record that was read
    logic finish;   // load the result register and close the request
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fits;     // the record under judgment can be granted
    logic last;     // the record under judgment is the last to scan
    logic out_free; // the result register can take a new result
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/rrdp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rrdp_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/rrdp_ctrl.sv @@
// Controller state machine of the round-robin device picker.
`timescale 1ns / 1ps
`default_nettype none

module rrdp_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic [rrdp_pkg::MODE_W-1:0] in_mode_i,
  output logic                             in_ready_o,
  input  wire rrdp_pkg::sts_t              sts_i,
  output rrdp_pkg::cmd_t                   cmd_o
);

  rrdp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrdp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      rrdp_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && (in_mode_i == rrdp_pkg::MODE_PICK)) begin
          cmd_o.start = 1'b1;
          state_d     = rrdp_pkg::ST_READ;
        end
      end
      rrdp_pkg::ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = rrdp_pkg::ST_EVAL;
      end
      rrdp_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.fits || sts_i.last) begin
          state_d = rrdp_pkg::ST_FINISH;
        end else begin
          state_d = rrdp_pkg::ST_READ;
        end
      end
      rrdp_pkg::ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = rrdp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rrdp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/rrdp_datapath.sv @@
// Datapath of the round-robin device picker: tables, scan pointer and result register.
`timescale 1ns / 1ps
`default_nettype none

module rrdp_datapath #(
  parameter int unsigned MAX_DEVICES = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire rrdp_pkg::cmd_t                  cmd_i,
  output rrdp_pkg::sts_t                       sts_o,
  // Configuration
  input  wire logic                            cfg_we_i,
  input  wire logic [rrdp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [rrdp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Request fields
  input  wire logic [rrdp_pkg::MODE_W-1:0]     mode_i,
  input  wire logic [rrdp_pkg::INDEX_W-1:0]    dev_index_i,
  input  wire logic [rrdp_pkg::TYPE_W-1:0]     dev_type_i,
  input  wire logic [rrdp_pkg::MEM_BITS-1:0]   dev_free_mem_i,
  input  wire logic [rrdp_pkg::PES_W-1:0]      dev_busy_pes_i,
  input  wire logic [rrdp_pkg::PES_W-1:0]      dev_pes_total_i,
  input  wire logic [rrdp_pkg::MEM_BITS-1:0]   data_size_i,
  input  wire logic [rrdp_pkg::TYPE_W-1:0]     data_devices_i,
  input  wire logic [rrdp_pkg::TYPE_W-1:0]     req_type_i,
  input  wire logic [rrdp_pkg::MEM_BITS-1:0]   req_mem_i,
  // Result
  input  wire logic                            out_ready_i,
  output logic                                 out_valid_o,
  output logic                                 granted_o,
  output logic [rrdp_pkg::INDEX_W-1:0]         device_o
);

  localparam int unsigned IW  = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int unsigned CW  = $clog2(MAX_DEVICES + 1);
  localparam int unsigned RD  = (MAX_DEVICES < 16) ? MAX_DEVICES : 16;
  localparam int unsigned RIW = (RD > 1) ? $clog2(RD) : 1;
  localparam int unsigned MW  = rrdp_pkg::MEM_BITS;

  // Configuration registers.
  logic [rrdp_pkg::NUM_W-1:0]  num_q;
  logic [rrdp_pkg::TYPE_W-1:0] bypass_q;

  // Scan state.
  logic [IW-1:0]               ptr_q, ptr_d;
  logic [IW-1:0]               idx_q;
  logic [CW-1:0]               cnt_q;
  logic                        found_q;
  logic [rrdp_pkg::TYPE_W-1:0] req_type_q;
  logic [MW-1:0]               req_mem_q;

  // Table state.
  logic [MAX_DEVICES-1:0]      valid_q;
  logic [MW-1:0]               res_q [RD];

  // Result register.
  logic                        out_valid_q;
  logic                        granted_q;
  logic [rrdp_pkg::INDEX_W-1:0] device_q;

  logic [CW-1:0]      active_n;
  logic [IW-1:0]      start_idx;
  logic [IW-1:0]      idx_next;
  logic               dev_we;
  logic [IW-1:0]      dev_waddr;
  rrdp_pkg::dev_rec_t wr_rec;
  rrdp_pkg::dev_rec_t rd_data;
  rrdp_pkg::dev_rec_t rec;
  logic [MW-1:0]      res_rd;
  logic [MW:0]        mem_sum;
  logic               type_ok;
  logic               mem_ok;
  logic               pes_ok;

  // Device count in use, clamped to 1..MAX_DEVICES.
  always_comb begin
    if (num_q == '0) begin
      active_n = CW'(1);
    end else if (32'(num_q) > 32'(MAX_DEVICES)) begin
      active_n = CW'(MAX_DEVICES);
    end else begin
      active_n = CW'(num_q);
    end
  end

  assign start_idx = (CW'(ptr_q) < active_n) ? ptr_q : '0;
  assign idx_next  = ((CW'(idx_q) + CW'(1)) < active_n) ? (idx_q + IW'(1)) : '0;

  // Device record writes.
  assign dev_we    = cmd_i.accept && (mode_i == rrdp_pkg::MODE_WRITE_DEV)
                     && (32'(dev_index_i) < 32'(MAX_DEVICES));
  assign dev_waddr = IW'(dev_index_i);

  always_comb begin
    wr_rec.dev_type  = dev_type_i;
    wr_rec.free_mem  = dev_free_mem_i;
    wr_rec.busy_pes  = dev_busy_pes_i;
    wr_rec.pes_total = dev_pes_total_i;
  end

  rrdp_ram #(
    .WIDTH ($bits(rrdp_pkg::dev_rec_t)),
    .DEPTH (MAX_DEVICES)
  ) u_dev_table (
    .clk_i   (clk_i),
    .we_i    (dev_we),
    .waddr_i (dev_waddr),
    .wdata_i (wr_rec),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  // A record never written reads as all zeros.
  assign rec    = valid_q[idx_q] ? rd_data : '0;
  assign res_rd = (32'(idx_q) < 32'(RD)) ? res_q[RIW'(idx_q)] : '0;

  // free >= req - resident (saturating at zero) is free + resident >= req.
  assign mem_sum = {1'b0, rec.free_mem} + {1'b0, res_rd};
  assign type_ok = (rec.dev_type & req_type_q) != '0;
  assign mem_ok  = (mem_sum >= {1'b0, req_mem_q}) || ((rec.dev_type & bypass_q) != '0);
  assign pes_ok  = rec.busy_pes <= rec.pes_total;

  assign sts_o.fits     = type_ok && mem_ok && pes_ok;
  assign sts_o.last     = (cnt_q + CW'(1)) == active_n;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.finish && found_q) begin
      ptr_d = idx_next;
    end
    if (cfg_we_i && (cfg_index_i == rrdp_pkg::REG_NUM_DEVICES)) begin
      ptr_d = '0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q       <= rrdp_pkg::NUM_W'(1);
      bypass_q    <= '0;
      ptr_q       <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ptr_q <= ptr_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          rrdp_pkg::REG_NUM_DEVICES: num_q    <= cfg_data_i[rrdp_pkg::NUM_W-1:0];
          rrdp_pkg::REG_BYPASS:      bypass_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (dev_we) begin
        valid_q[dev_waddr] <= 1'b1;
      end
      if (cmd_i.start) begin
        idx_q   <= start_idx;
        cnt_q   <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.eval) begin
        if (sts_o.fits) begin
          found_q <= 1'b1;
        end else if (!sts_o.last) begin
          idx_q <= idx_next;
          cnt_q <= cnt_q + CW'(1);
        end
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: request operands, result and resident accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < RD; d++) begin
        res_q[d] <= '0;
      end
    end else begin
      if (cmd_i.finish) begin
        for (int d = 0; d < RD; d++) begin
          res_q[d] <= '0;
        end
      end else if (cmd_i.accept && (mode_i == rrdp_pkg::MODE_RESIDENT)) begin
        for (int d = 0; d < RD; d++) begin
          if (data_devices_i[d]) begin
            if (({1'b0, res_q[d]} + {1'b0, data_size_i}) > {1'b0, {MW{1'b1}}}) begin
              res_q[d] <= {MW{1'b1}};
            end else begin
              res_q[d] <= res_q[d] + data_size_i;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_type_q <= req_type_i;
      req_mem_q  <= req_mem_i;
    end
    if (cmd_i.finish) begin
      granted_q <= found_q;
      device_q  <= found_q ? rrdp_pkg::INDEX_W'(idx_q) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign granted_o   = granted_q;
  assign device_o    = device_q;

endmodule

`default_nettype wire

@@ rtl/round_robin_device_picker_top.sv @@
// Top level of the round-robin device picker.
//
// The block keeps a table of devices and grants scheduling requests to them
// in round-robin order. Requests arrive on the s_axis channel; tuser carries
// the request kind: write a device record, add a resident data item, or pick
// a device. Only a pick request produces a result, which leaves on the
// m_axis channel with the granted flag in tuser and the device index in
// tdata. The two configuration registers (device count and memory bypass
// types) are written through the cfg port; the user must write them only
// while the block is idle, as the block does not enforce it. Record writes
// and resident data items complete in the cycle they are taken, so such
// requests may follow each other every cycle while the block is idle. A pick
// request reads one device record from the table memory and judges it in the
// next cycle, until one fits or the last device in use is judged; the
// registered memory read sets this step. The result sits in an output
// register, so a new request is taken while it still waits for the receiver;
// if that receiver stalls, the next pick request finishes its scan and then
// waits. Reset empties the device table, clears the resident accumulators,
// sets the device count to one and the round-robin pointer to zero.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_device_picker_top #(
  parameter int unsigned MAX_DEVICES = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration write port.
  input  wire logic                            cfg_we_i,
  input  wire logic [rrdp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [rrdp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Request channel.
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata from bit 0: dev_index[3:0], dev_type[19:4], dev_free_mem[67:20],
  // dev_busy_pes[83:68], dev_pes_total[99:84], data_size[147:100],
  // data_devices[163:148], req_type[179:164], req_mem[227:180], zero pad.
  input  wire logic [231:0]                    s_axis_tdata,
  // tuser: mode[1:0].
  input  wire logic [rrdp_pkg::MODE_W-1:0]     s_axis_tuser,
  // Result channel.
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // tdata from bit 0: device[3:0], zero pad.
  output logic [7:0]                           m_axis_tdata,
  // tuser: granted[0].
  output logic                                 m_axis_tuser
);

  rrdp_pkg::cmd_t cmd;
  rrdp_pkg::sts_t sts;
  logic [rrdp_pkg::INDEX_W-1:0] device;

  rrdp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rrdp_datapath #(
    .MAX_DEVICES (MAX_DEVICES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .mode_i          (s_axis_tuser),
    .dev_index_i     (s_axis_tdata[3:0]),
    .dev_type_i      (s_axis_tdata[19:4]),
    .dev_free_mem_i  (s_axis_tdata[67:20]),
    .dev_busy_pes_i  (s_axis_tdata[83:68]),
    .dev_pes_total_i (s_axis_tdata[99:84]),
    .data_size_i     (s_axis_tdata[147:100]),
    .data_devices_i  (s_axis_tdata[163:148]),
    .req_type_i      (s_axis_tdata[179:164]),
    .req_mem_i       (s_axis_tdata[227:180]),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .granted_o       (m_axis_tuser),
    .device_o        (device)
  );

  assign m_axis_tdata = {4'd0, device};

endmodule

`default_nettype wire
